// File: design/ordered_list_engine_top_assert.svh
// Assertion macros for the ordered list engine top level.
// Depends on nothing; included by ordered_list_engine_top.sv.
`ifndef ORDERED_LIST_ENGINE_TOP_ASSERT_SVH
`define ORDERED_LIST_ENGINE_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define OLE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("ordered list engine check failed");
// Next-cycle implication.
`define OLE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("ordered list engine check failed");
`endif

// File: design/ole_pkg.sv
// Package for the ordered list engine: sizes, command and status codes.
// No dependencies.
package ole_pkg;
	localparam int Capacity = 64;
	localparam int IdxW = $clog2(Capacity);
	localparam int CntW = $clog2(Capacity + 1);

	typedef enum logic [2:0] {
		CMD_INS_FIRST = 3'd0,
		CMD_INS_LAST  = 3'd1,
		CMD_INS_AFTER = 3'd2,
		CMD_DEL_FIRST = 3'd3,
		CMD_DEL_LAST  = 3'd4,
		CMD_DEL_AT    = 3'd5,
		CMD_SORT      = 3'd6,
		CMD_TRAVERSE  = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_NOPOS = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [31:0] item_value;
		status_t            status;
		logic [CntW-1:0]    element_count;
		logic               last;
	} result_t;
endpackage

// File: design/ole_store.sv
// Element memory of the ordered list engine: one write port, one registered read.
// Depends on ole_pkg.
module ole_store (
	input  logic                    clk,
	input  logic                    wr_en,
	input  logic [ole_pkg::IdxW-1:0] wr_addr,
	input  logic [31:0]             wr_data,
	input  logic [ole_pkg::IdxW-1:0] rd_addr,
	output logic [31:0]             rd_data
);
	import ole_pkg::*;

	logic [31:0] mem_q [Capacity];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

// File: design/ordered_list_engine_top.sv
// Top level of the ordered list engine: command sequencer around one memory port.
// Depends on ole_pkg, ole_store and ordered_list_engine_top_assert.svh.
//
// Usage: commands arrive on the s_axis channel (tdata: value, position;
// tuser: command). Results leave on m_axis (tdata: item_value, status,
// element_count; tlast marks the final result of a command).
// One command at a time: s_axis_tready is high only while the sequencer idles
// and the output register is free or being emptied.
// Every shift, compare and swap goes through the memory's one write port and
// one registered read port, so the commands step through them in order:
//   rejected commands, delete-last, one-element deletes, short sort: answered from idle;
//   insert-last: the new value is written straight away;
//   other inserts and deletes: one read and one write per shifted entry (an insert then writes the new value);
//   sort (exchange sort): read i, read j, compare and swap for each of the N*(N-1)/2 pairs;
//   traverse: one read per emitted value.
// A result sits in an output register; when m_axis_tready is low the
// sequencer holds until it is taken. Reset empties the list (count to zero)
// and drops any result in flight; the memory itself is not cleared.
`include "ordered_list_engine_top_assert.svh"
module ordered_list_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [31:0] value, [38:32] position, [39] zero
	input  logic [2:0]  s_axis_tuser,   // [2:0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [31:0] item_value, [33:32] status,
	                                    // [40:34] element_count, [47:41] zero
	output logic        m_axis_tlast
);
	import ole_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_SHIFT = 8'b0000_0010,  // read source entry
		S_MOVE  = 8'b0000_0100,  // write it to its new place
		S_SRDI  = 8'b0000_1000,  // sort: read entry i
		S_SRDJ  = 8'b0001_0000,  // sort: read entry j, latch i
		S_SCMP  = 8'b0010_0000,  // sort: compare, write swap
		S_TRD   = 8'b0100_0000,  // traverse: read
		S_OUT   = 8'b1000_0000   // wait for output register
	} state_t;

	state_t state_q;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] i_q, j_q, stop_q;
	logic [31:0] val_q, vi_q;
	cmd_t cmd_q;
	logic up_q;
	logic emit_last_q;

	logic out_valid_q;
	result_t out_q;

	// Sort writes its j-side in S_OUT using vi_q; track it.
	logic swap_j_q;
	logic [IdxW-1:0] jw_addr_q;

	logic wr_en;
	logic [IdxW-1:0] wr_addr, rd_addr;
	logic [31:0] wr_data, rd_data;

	ole_store u_store (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_addr(rd_addr), .rd_data(rd_data)
	);

	cmd_t in_cmd;
	logic [CntW-1:0] in_pos;
	assign in_cmd = cmd_t'(s_axis_tuser);
	assign in_pos = s_axis_tdata[38:32];

	logic accept, out_free;
	assign out_free = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && out_free;
	assign accept = s_axis_tvalid && s_axis_tready;

	// Shared signed compare unit for sort.
	logic swap;
	assign swap = $signed(vi_q) > $signed(rd_data);

	// Memory port control.
	always_comb begin
		wr_en = 1'b0;
		wr_addr = i_q[IdxW-1:0];
		wr_data = rd_data;
		rd_addr = i_q[IdxW-1:0];
		case (state_q)
			S_SHIFT: rd_addr = up_q ? IdxW'(i_q - 1'b1) : IdxW'(i_q + 1'b1);
			S_MOVE: begin
				wr_en = 1'b1;
				wr_addr = i_q[IdxW-1:0];
			end
			S_SRDI: rd_addr = i_q[IdxW-1:0];
			S_SRDJ: rd_addr = j_q[IdxW-1:0];
			S_SCMP: begin
				wr_en = swap;
				wr_addr = i_q[IdxW-1:0];
				wr_data = rd_data;
			end
			S_TRD: rd_addr = i_q[IdxW-1:0];
			S_OUT: begin
				// entry j takes the old entry i after a swap
				wr_en = swap_j_q;
				wr_addr = jw_addr_q;
				wr_data = vi_q;
			end
			default: ;
		endcase
		// final insert write of the new value
		if (state_q == S_SHIFT && i_q == stop_q && up_q) begin
			wr_en = 1'b1;
			wr_addr = i_q[IdxW-1:0];
			wr_data = val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
			swap_j_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			swap_j_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= in_cmd;
						val_q <= s_axis_tdata[31:0];
						out_q.item_value <= '0;
						out_q.last <= 1'b1;
						out_q.status <= ST_OK;
						out_q.element_count <= count_q;
						case (in_cmd)
							CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AFTER: begin
								if (in_cmd == CMD_INS_AFTER && count_q == '0) begin
									out_q.status <= ST_EMPTY;
									out_valid_q <= 1'b1;
								end else if (in_cmd == CMD_INS_AFTER && in_pos > count_q) begin
									out_q.status <= ST_NOPOS;
									out_valid_q <= 1'b1;
								end else if (count_q == CntW'(Capacity)) begin
									out_q.status <= ST_FULL;
									out_valid_q <= 1'b1;
								end else begin
									up_q <= 1'b1;
									i_q <= count_q;
									if (in_cmd == CMD_INS_FIRST) begin
										stop_q <= '0;
									end else if (in_cmd == CMD_INS_LAST) begin
										stop_q <= count_q;
									end else begin
										stop_q <= (in_pos < CntW'(1)) ? CntW'(1) : in_pos;
									end
									count_q <= count_q + 1'b1;
									state_q <= S_SHIFT;
								end
							end
							CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT: begin
								if (count_q == '0) begin
									out_q.status <= ST_EMPTY;
									out_valid_q <= 1'b1;
								end else if (in_cmd == CMD_DEL_LAST || count_q == CntW'(1)) begin
									count_q <= (in_cmd == CMD_DEL_LAST) ?
										count_q - 1'b1 : '0;
									out_q.element_count <= (in_cmd == CMD_DEL_LAST) ?
										count_q - 1'b1 : '0;
									out_valid_q <= 1'b1;
								end else if (in_cmd == CMD_DEL_AT &&
										(in_pos == '0 || in_pos > count_q)) begin
									out_q.status <= ST_NOPOS;
									out_valid_q <= 1'b1;
								end else begin
									up_q <= 1'b0;
									i_q <= (in_cmd == CMD_DEL_FIRST) ? '0 : in_pos - 1'b1;
									stop_q <= count_q - 1'b1;
									count_q <= count_q - 1'b1;
									state_q <= S_SHIFT;
								end
							end
							CMD_SORT: begin
								if (count_q < CntW'(2)) begin
									out_valid_q <= 1'b1;
								end else begin
									i_q <= '0;
									j_q <= CntW'(1);
									state_q <= S_SRDI;
								end
							end
							default: begin
								if (count_q == '0) begin
									out_q.status <= ST_EMPTY;
									out_valid_q <= 1'b1;
								end else begin
									i_q <= '0;
									state_q <= S_TRD;
								end
							end
						endcase
					end
				end
				S_SHIFT: begin
					// on an insert, the new value is written here when i reaches the gap
					if (i_q == stop_q) begin
						out_q.element_count <= count_q;
						emit_last_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_MOVE;
					end
				end
				S_MOVE: begin
					i_q <= up_q ? i_q - 1'b1 : i_q + 1'b1;
					state_q <= S_SHIFT;
				end
				S_SRDI: state_q <= S_SRDJ;
				S_SRDJ: begin
					vi_q <= rd_data;
					state_q <= S_SCMP;
				end
				S_SCMP: begin
					if (swap) begin
						swap_j_q <= 1'b1;
					end
					if (j_q + 1'b1 < count_q) begin
						j_q <= j_q + 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
						j_q <= i_q + CntW'(2);
					end
					state_q <= S_OUT;
					emit_last_q <= 1'b0;
				end
				S_TRD: state_q <= S_OUT;
				S_OUT: begin
					if (cmd_q == CMD_SORT) begin
						if (emit_last_q) begin
							if (out_free) begin
								out_q.item_value <= '0;
								out_q.status <= ST_OK;
								out_q.element_count <= count_q;
								out_q.last <= 1'b1;
								out_valid_q <= 1'b1;
								state_q <= S_IDLE;
							end
						end else if (i_q + 1'b1 >= count_q) begin
							emit_last_q <= 1'b1;
						end else begin
							state_q <= S_SRDI;
						end
					end else if (cmd_q == CMD_TRAVERSE) begin
						if (out_free) begin
							out_q.item_value <= rd_data;
							out_q.status <= ST_OK;
							out_q.element_count <= count_q;
							out_q.last <= (i_q + 1'b1 == count_q);
							out_valid_q <= 1'b1;
							if (i_q + 1'b1 == count_q) begin
								state_q <= S_IDLE;
							end else begin
								i_q <= i_q + 1'b1;
								state_q <= S_TRD;
							end
						end
					end else if (out_free) begin
						out_q.item_value <= '0;
						out_q.status <= ST_OK;
						out_q.last <= 1'b1;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold the j address of the compared pair for the swap write in S_OUT.
	always_ff @(posedge clk) begin
		if (state_q == S_SCMP) begin
			jw_addr_q <= j_q[IdxW-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast = out_q.last;
	assign m_axis_tdata = {7'd0, out_q.element_count, out_q.status, out_q.item_value};

	`OLE_ASSERT_IMP(a_ready_idle, s_axis_tready, state_q == S_IDLE)
	`OLE_ASSERT_IMP(a_count_cap, 1'b1, count_q <= CntW'(Capacity))
	`OLE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
endmodule

// File: tb/testbench.sv
// Self-checking testbench for the ordered list engine: a table of directed
// commands, then random command streams, checked against a behavioral list model.
// Depends on ole_pkg and ordered_list_engine_top.
module testbench;
	import ole_pkg::*;

	typedef struct {
		cmd_t        cmd;
		logic [31:0] val;
		logic [6:0]  pos;
		logic        chk;      // typed-in expectation present
		status_t     st;
		logic [6:0]  cnt;
	} row_t;

	typedef struct {
		logic [31:0] val;
		status_t     st;
		logic [6:0]  cnt;
		logic        last;
	} res_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;

	ordered_list_engine_top i_dut (.*);

	logic [31:0] list_mem[Capacity];
	int          list_len;
	res_t        pending_results[$];
	int          mismatches;
	int          results_seen;
	int          cmds_sent;
	int          cycles;
	int          send_idle;
	int          recv_idle;
	bit          hold_off;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Apply one command to the list model and queue what it should produce.
	task automatic model_command(input cmd_t c, input logic [31:0] v, input logic [6:0] p);
		status_t st;
		int i, j, idx;
		logic [31:0] t;
		st = ST_OK;
		case (c)
			CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AFTER: begin
				idx = (c == CMD_INS_FIRST) ? 0 :
					(c == CMD_INS_LAST) ? list_len : (p < 1 ? 1 : p);
				if (c == CMD_INS_AFTER && list_len == 0) st = ST_EMPTY;
				else if (c == CMD_INS_AFTER && p > list_len) st = ST_NOPOS;
				else if (list_len >= Capacity) st = ST_FULL;
				else begin
					for (i = list_len; i > idx; i--) list_mem[i] = list_mem[i-1];
					list_mem[idx] = v;
					list_len++;
				end
			end
			CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT: begin
				idx = (c == CMD_DEL_FIRST) ? 0 :
					(c == CMD_DEL_LAST) ? list_len - 1 : p - 1;
				if (list_len == 0) st = ST_EMPTY;
				else if (c == CMD_DEL_AT && list_len == 1) list_len = 0;
				else if (c == CMD_DEL_AT && (p < 1 || p > list_len)) st = ST_NOPOS;
				else begin
					for (i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			CMD_SORT: begin
				for (i = 0; i < list_len; i++)
					for (j = i + 1; j < list_len; j++)
						if ($signed(list_mem[i]) > $signed(list_mem[j])) begin
							t = list_mem[i];
							list_mem[i] = list_mem[j];
							list_mem[j] = t;
						end
			end
			default: begin
				if (list_len == 0) st = ST_EMPTY;
				else begin
					for (i = 0; i < list_len; i++)
						pending_results.push_back('{list_mem[i], ST_OK, 7'(list_len),
							i + 1 == list_len});
					return;
				end
			end
		endcase
		pending_results.push_back('{32'd0, st, 7'(list_len), 1'b1});
	endtask

	// Drop tvalid only while idling, so back-to-back transactions keep it high.
	task automatic send_command(input cmd_t c, input logic [31:0] v, input logic [6:0] p);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		model_command(c, v, p);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= c;
		s_axis_tdata  <= {1'b0, p, v};
		do @(posedge clk); while (!s_axis_tready);
		cmds_sent++;
		@(negedge clk);
	endtask

	// Receiver: random stalls plus one long hold-off.
	always @(negedge clk) begin
		if (!arst_n) m_axis_tready <= 1'b0;
		else m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		res_t exp_r;
		cycles++;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
			end else begin
				exp_r = pending_results.pop_front();
				if (m_axis_tdata[31:0] !== exp_r.val || m_axis_tdata[33:32] !== exp_r.st ||
				    m_axis_tdata[40:34] !== exp_r.cnt || m_axis_tdata[47:41] !== 7'd0 ||
				    m_axis_tlast !== exp_r.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp val %h st %0d cnt %0d last %b,",
							" got val %h st %0d cnt %0d last %b"},
							exp_r.val, exp_r.st, exp_r.cnt, exp_r.last, m_axis_tdata[31:0],
							m_axis_tdata[33:32], m_axis_tdata[40:34], m_axis_tlast);
				end
			end
		end
		if (cycles > 2000000) begin
			$display("testbench failed");
			$finish;
		end
	end

	// Long receiver hold-off while the sender keeps offering commands.
	initial begin
		int n;
		hold_off = 0;
		wait (cmds_sent >= 60);
		@(posedge clk);
		hold_off = 1;
		for (n = 0; n < 400; n++) @(posedge clk);
		hold_off = 0;
	end

	function automatic logic [31:0] rand_value();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'(int'($urandom_range(20)) - 10);
			default: return $urandom;
		endcase
	endfunction

	row_t dir_rows[] = '{
		'{CMD_TRAVERSE,  32'd0,        7'd0,   1, ST_EMPTY, 7'd0},
		'{CMD_DEL_FIRST, 32'd0,        7'd0,   1, ST_EMPTY, 7'd0},
		'{CMD_DEL_LAST,  32'd0,        7'd0,   1, ST_EMPTY, 7'd0},
		'{CMD_DEL_AT,    32'd0,        7'd1,   1, ST_EMPTY, 7'd0},
		'{CMD_INS_AFTER, 32'd5,        7'd1,   1, ST_EMPTY, 7'd0},
		'{CMD_SORT,      32'd0,        7'd0,   1, ST_OK,    7'd0},
		'{CMD_INS_FIRST, 32'h7fffffff, 7'd0,   1, ST_OK,    7'd1},
		'{CMD_DEL_AT,    32'd0,        7'd127, 1, ST_OK,    7'd0},
		'{CMD_INS_LAST,  32'h80000000, 7'd0,   1, ST_OK,    7'd1},
		'{CMD_INS_FIRST, 32'h7fffffff, 7'd0,   1, ST_OK,    7'd2},
		'{CMD_INS_AFTER, 32'hffffffff, 7'd0,   1, ST_OK,    7'd3},
		'{CMD_INS_AFTER, 32'd1,        7'd4,   1, ST_NOPOS, 7'd3},
		'{CMD_INS_AFTER, 32'd2,        7'd3,   1, ST_OK,    7'd4},
		'{CMD_TRAVERSE,  32'd0,        7'd0,   0, ST_OK,    7'd0},
		'{CMD_SORT,      32'd0,        7'd0,   1, ST_OK,    7'd4},
		'{CMD_TRAVERSE,  32'd0,        7'd0,   0, ST_OK,    7'd0},
		'{CMD_DEL_AT,    32'd0,        7'd0,   1, ST_NOPOS, 7'd4},
		'{CMD_DEL_AT,    32'd0,        7'd5,   1, ST_NOPOS, 7'd4},
		'{CMD_DEL_AT,    32'd0,        7'd2,   1, ST_OK,    7'd3},
		'{CMD_DEL_FIRST, 32'd0,        7'd0,   1, ST_OK,    7'd2},
		'{CMD_DEL_LAST,  32'd0,        7'd0,   1, ST_OK,    7'd1},
		'{CMD_TRAVERSE,  32'd0,        7'd0,   0, ST_OK,    7'd0}
	};

	initial begin
		int k, n, phase;
		cmd_t c;
		res_t tail;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 0;
		mismatches = 0;
		results_seen = 0;
		cmds_sent = 0;
		cycles = 0;
		list_len = 0;
		send_idle = 24;
		recv_idle = 79;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		foreach (dir_rows[k]) begin
			send_command(dir_rows[k].cmd, dir_rows[k].val, dir_rows[k].pos);
			tail = pending_results[$];
			if (dir_rows[k].chk &&
			    (tail.st !== dir_rows[k].st || tail.cnt !== dir_rows[k].cnt)) begin
				mismatches++;
				$display("table row %0d disagrees with list model", k);
			end
		end

		for (phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 24 : (phase == 1) ? 79 : 0;
			recv_idle = (phase == 0) ? 79 : (phase == 1) ? 24 : 0;
			// Fill to capacity once so the full-list answers come up.
			if (phase == 1) begin
				while (list_len < Capacity) send_command(CMD_INS_LAST, rand_value(), 7'd0);
				send_command(CMD_INS_FIRST, 32'd1, 7'd0);
				send_command(CMD_INS_AFTER, 32'd1, 7'd64);
				send_command(CMD_INS_AFTER, 32'd1, 7'd100);
				send_command(CMD_SORT, 32'd0, 7'd0);
				send_command(CMD_TRAVERSE, 32'd0, 7'd0);
				send_command(CMD_DEL_AT, 32'd0, 7'd64);
				while (list_len > 40)
					send_command(CMD_DEL_AT, 32'd0, 7'($urandom_range(1, list_len)));
			end
			for (n = 0; n < 20; n++) begin
				k = $urandom_range(99);
				if (k < 45) c = cmd_t'($urandom_range(CMD_INS_AFTER));
				else if (k < 80) c = cmd_t'($urandom_range(CMD_DEL_AT, CMD_DEL_FIRST));
				else c = cmd_t'($urandom_range(CMD_TRAVERSE, CMD_SORT));
				if (list_len > 12 && c <= CMD_INS_AFTER && $urandom_range(1)) c = CMD_DEL_LAST;
				send_command(c, rand_value(),
					$urandom_range(3) == 0 ? 7'($urandom) : 7'($urandom_range(list_len + 1)));
			end
		end
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		$display("ran %0d commands, %0d results checked, final list length %0d",
			cmds_sent, results_seen, list_len);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule

// File: files.f
+incdir+design
design/ole_pkg.sv
design/ole_store.sv
design/ordered_list_engine_top.sv
tb/testbench.sv
